// ----- hw/rtl/nearest_typed_point_search_top_assert.svh -----
// ----------------------------------------------------------------------------
// nearest typed point search assertion macros
// shared concurrent assertion forms used by the top level
// ----------------------------------------------------------------------------
`ifndef NEAREST_TYPED_POINT_SEARCH_TOP_ASSERT_SVH
`define NEAREST_TYPED_POINT_SEARCH_TOP_ASSERT_SVH

// same-cycle implication
`define NTPS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ntps assertion failed");

// next-cycle implication
`define NTPS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ntps assertion failed");

`endif

// ----- hw/rtl/ntps_pkg.sv -----
// ----------------------------------------------------------------------------
// ntps_pkg
// shared constants, codes and types of the nearest typed point search
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ntps_pkg;

   localparam int MAX_POINTS = 64;
   localparam int CNT_W      = $clog2(MAX_POINTS + 1);
   localparam int ADDR_W     = $clog2(MAX_POINTS);
   localparam int INDEX_W    = 7;
   localparam int TYPE_W     = 4;
   localparam int COORD_W    = 8;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 4;

   localparam logic [COORD_W-1:0] BEST_INIT = 8'd255;

   typedef enum logic [1:0] {
      REQ_ADD   = 2'd0,
      REQ_QUERY = 2'd1,
      REQ_LOCK  = 2'd2,
      REQ_NONE  = 2'd3
   } req_code_type;

   typedef enum logic [1:0] {
      ADD_OK     = 2'd0,
      ADD_LOCKED = 2'd1,
      ADD_FULL   = 2'd2,
      ADD_UNUSED = 2'd3
   } add_status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAT_FIRST = 1'b0,
      CSR_MAT_LAST  = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [TYPE_W-1:0]  ptype;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
   } mat_entry_type;

   typedef struct packed {
      logic load;
      logic issue;
      logic commit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic scan_needed;
      logic last_addr;
      logic out_free;
   } dp_status_type;

endpackage

// ----- hw/rtl/ntps_if.sv -----
// ----------------------------------------------------------------------------
// ntps channel interfaces
// valid/ready channels for requests and responses
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ntps_req_if;
   logic                            valid;
   logic                            ready;
   logic [1:0]                      req_type;
   logic [ntps_pkg::TYPE_W-1:0]     point_type;
   logic [ntps_pkg::COORD_W-1:0]    pos_x;
   logic [ntps_pkg::COORD_W-1:0]    pos_y;

   modport source (output valid, req_type, point_type, pos_x, pos_y, input ready);
   modport sink   (input valid, req_type, point_type, pos_x, pos_y, output ready);
endinterface

interface ntps_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [ntps_pkg::INDEX_W-1:0]    point_index;
   logic [1:0]                      add_status;
   logic [ntps_pkg::COORD_W-1:0]    best_x;
   logic [ntps_pkg::COORD_W-1:0]    best_y;
   logic                            found;

   modport source (output valid, point_index, add_status, best_x, best_y, found,
                   input ready);
   modport sink   (input valid, point_index, add_status, best_x, best_y, found,
                   output ready);
endinterface

// ----- hw/rtl/ntps_ctrl.sv -----
// ----------------------------------------------------------------------------
// ntps_ctrl
// sequencing of request load, table scan and response commit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ntps_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  ntps_pkg::dp_status_type status,
   output ntps_pkg::ctrl_cmd_type  cmd
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_DRAIN  = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_ready  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = status.scan_needed ? ST_SCAN : ST_FINISH;
            end
         end
         ST_SCAN: begin
            cmd.issue = 1'b1;
            if (status.last_addr) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- hw/rtl/ntps_datapath.sv -----
// ----------------------------------------------------------------------------
// ntps_datapath
// point table, material store, distance compare and response register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ntps_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  ntps_pkg::ctrl_cmd_type              cmd,
   output ntps_pkg::dp_status_type             status,
   input  logic                                csr_write_en,
   input  logic [ntps_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ntps_pkg::CSR_DATA_W-1:0]     csr_write_data,
   input  logic [1:0]                          in_req_type,
   input  logic [ntps_pkg::TYPE_W-1:0]         in_point_type,
   input  logic [ntps_pkg::COORD_W-1:0]        in_pos_x,
   input  logic [ntps_pkg::COORD_W-1:0]        in_pos_y,
   output logic                                out_valid,
   input  logic                                out_ready,
   output logic [ntps_pkg::INDEX_W-1:0]        out_point_index,
   output logic [1:0]                          out_add_status,
   output logic [ntps_pkg::COORD_W-1:0]        out_best_x,
   output logic [ntps_pkg::COORD_W-1:0]        out_best_y,
   output logic                                out_found
);

   ntps_pkg::mat_entry_type mem [ntps_pkg::MAX_POINTS];

   logic [ntps_pkg::TYPE_W-1:0]   mat_first_ff;
   logic [ntps_pkg::TYPE_W-1:0]   mat_last_ff;
   logic [ntps_pkg::CNT_W-1:0]    point_count_ff;
   logic [ntps_pkg::CNT_W-1:0]    point_count_in;
   logic [ntps_pkg::CNT_W-1:0]    mat_count_ff;
   logic [ntps_pkg::CNT_W-1:0]    mat_count_in;
   logic                          locked_ff;
   logic                          locked_in;

   logic [1:0]                    req_type_ff;
   logic [ntps_pkg::TYPE_W-1:0]   ptype_ff;
   logic [ntps_pkg::COORD_W-1:0]  qx_ff;
   logic [ntps_pkg::COORD_W-1:0]  qy_ff;

   logic [ntps_pkg::ADDR_W-1:0]   rd_addr_ff;
   logic                          cmp_vld_ff;
   ntps_pkg::mat_entry_type       rd_data_ff;

   logic [ntps_pkg::COORD_W-1:0]  best_d_ff;
   logic [ntps_pkg::COORD_W-1:0]  best_x_ff;
   logic [ntps_pkg::COORD_W-1:0]  best_y_ff;
   logic                          found_ff;

   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   logic [ntps_pkg::INDEX_W-1:0]  rsp_index_ff;
   logic [1:0]                    rsp_status_ff;
   logic [ntps_pkg::COORD_W-1:0]  rsp_x_ff;
   logic [ntps_pkg::COORD_W-1:0]  rsp_y_ff;
   logic                          rsp_found_ff;

   logic                          is_add;
   logic                          is_query;
   logic                          is_lock;
   logic                          full;
   logic                          is_material;
   logic                          do_add;
   logic                          do_store;
   logic [ntps_pkg::COORD_W-1:0]  dx;
   logic [ntps_pkg::COORD_W-1:0]  dy;
   logic [ntps_pkg::COORD_W-1:0]  gap_sum;
   logic                          win;
   logic [1:0]                    add_status;

   assign is_add   = (req_type_ff == ntps_pkg::REQ_ADD);
   assign is_query = (req_type_ff == ntps_pkg::REQ_QUERY);
   assign is_lock  = (req_type_ff == ntps_pkg::REQ_LOCK);
   assign full     = (point_count_ff >= ntps_pkg::CNT_W'(ntps_pkg::MAX_POINTS));
   assign is_material = (ptype_ff >= mat_first_ff) && (ptype_ff <= mat_last_ff)
                        && (mat_count_ff < ntps_pkg::CNT_W'(ntps_pkg::MAX_POINTS));
   assign do_add   = cmd.commit && is_add && !locked_ff && !full;
   assign do_store = do_add && is_material;

   always_comb begin
      if (!is_add) begin
         add_status = ntps_pkg::ADD_OK;
      end else if (locked_ff) begin
         add_status = ntps_pkg::ADD_LOCKED;
      end else if (full) begin
         add_status = ntps_pkg::ADD_FULL;
      end else begin
         add_status = ntps_pkg::ADD_OK;
      end
   end

   // distance of the entry read last cycle, wrapped to 8 bits
   assign dx   = (rd_data_ff.x > qx_ff) ? rd_data_ff.x - qx_ff : qx_ff - rd_data_ff.x;
   assign dy   = (rd_data_ff.y > qy_ff) ? rd_data_ff.y - qy_ff : qy_ff - rd_data_ff.y;
   assign gap_sum = dx + dy;
   assign win  = cmp_vld_ff && (rd_data_ff.ptype == ptype_ff) && (gap_sum < best_d_ff);

   assign status.scan_needed = (in_req_type == ntps_pkg::REQ_QUERY)
                               && (mat_count_ff != '0);
   assign status.last_addr   = ((ntps_pkg::CNT_W'(rd_addr_ff) + ntps_pkg::CNT_W'(1))
                                == mat_count_ff);
   assign status.out_free    = !rsp_valid_ff || out_ready;

   assign point_count_in = do_add ? point_count_ff + ntps_pkg::CNT_W'(1) : point_count_ff;
   assign mat_count_in   = do_store ? mat_count_ff + ntps_pkg::CNT_W'(1) : mat_count_ff;
   assign locked_in      = locked_ff || (cmd.commit && is_lock);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (out_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         mat_first_ff   <= '0;
         mat_last_ff    <= '1;
         point_count_ff <= '0;
         mat_count_ff   <= '0;
         locked_ff      <= 1'b0;
         cmp_vld_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               ntps_pkg::CSR_MAT_FIRST: mat_first_ff <= csr_write_data;
               ntps_pkg::CSR_MAT_LAST:  mat_last_ff  <= csr_write_data;
               default: begin
               end
            endcase
         end
         point_count_ff <= point_count_in;
         mat_count_ff   <= mat_count_in;
         locked_ff      <= locked_in;
         cmp_vld_ff     <= cmd.issue;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // request capture, scan address and running minimum
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_type_ff <= in_req_type;
         ptype_ff    <= in_point_type;
         qx_ff       <= in_pos_x;
         qy_ff       <= in_pos_y;
         rd_addr_ff  <= '0;
         best_d_ff   <= ntps_pkg::BEST_INIT;
         best_x_ff   <= in_pos_x;
         best_y_ff   <= in_pos_y;
         found_ff    <= 1'b0;
      end else begin
         if (cmd.issue) begin
            rd_addr_ff <= rd_addr_ff + ntps_pkg::ADDR_W'(1);
         end
         if (win) begin
            best_d_ff <= gap_sum;
            best_x_ff <= rd_data_ff.x;
            best_y_ff <= rd_data_ff.y;
            found_ff  <= 1'b1;
         end
      end
   end

   // material store
   always_ff @(posedge clock) begin
      if (do_store) begin
         mem[mat_count_ff[ntps_pkg::ADDR_W-1:0]] <= '{ptype: ptype_ff, x: qx_ff, y: qy_ff};
      end
      if (cmd.issue) begin
         rd_data_ff <= mem[rd_addr_ff];
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_index_ff  <= ntps_pkg::INDEX_W'(point_count_ff);
         rsp_status_ff <= add_status;
         rsp_x_ff      <= is_query ? best_x_ff : '0;
         rsp_y_ff      <= is_query ? best_y_ff : '0;
         rsp_found_ff  <= is_query && found_ff;
      end
   end

   assign out_valid       = rsp_valid_ff;
   assign out_point_index = rsp_index_ff;
   assign out_add_status  = rsp_status_ff;
   assign out_best_x      = rsp_x_ff;
   assign out_best_y      = rsp_y_ff;
   assign out_found       = rsp_found_ff;

endmodule

// ----- hw/rtl/nearest_typed_point_search_top.sv -----
// ----------------------------------------------------------------------------
// nearest_typed_point_search_top
// typed point table with nearest same-type manhattan search
// ----------------------------------------------------------------------------
// One request is in flight at a time. An add, a lock, an unused code or a
// query with an empty material store goes from acceptance straight to the
// commit state; any other query first scans the material store, one entry
// per cycle since the store has a single read port, then passes a compare
// (drain) state before the commit. The response register is loaded at the
// commit, and the controller is back in idle in the cycle after it, so a new
// request is taken only once the previous one has committed. The response
// sits in an output register, so the next request is accepted even while the
// previous response has not been taken; that request then waits at its commit
// until the register is free.
`timescale 1ns / 1ps

module nearest_typed_point_search_top (
   input  logic                              clock,
   input  logic                              reset,
   ntps_req_if.sink                          req_if,
   ntps_rsp_if.source                        rsp_if,
   input  logic                              csr_write_en,
   input  logic [ntps_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ntps_pkg::CSR_DATA_W-1:0]   csr_write_data
);

   `include "nearest_typed_point_search_top_assert.svh"

   ntps_pkg::ctrl_cmd_type  cmd;
   ntps_pkg::dp_status_type status;

   ntps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   ntps_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data),
      .in_req_type     (req_if.req_type),
      .in_point_type   (req_if.point_type),
      .in_pos_x        (req_if.pos_x),
      .in_pos_y        (req_if.pos_y),
      .out_valid       (rsp_if.valid),
      .out_ready       (rsp_if.ready),
      .out_point_index (rsp_if.point_index),
      .out_add_status  (rsp_if.add_status),
      .out_best_x      (rsp_if.best_x),
      .out_best_y      (rsp_if.best_y),
      .out_found       (rsp_if.found)
   );

   `NTPS_ASSERT_SAME(a_no_accept_in_scan, clock, reset, cmd.issue, !req_if.ready)
   `NTPS_ASSERT_SAME(a_commit_needs_room, clock, reset, cmd.commit, status.out_free)
   `NTPS_ASSERT_NEXT(a_commit_shows_rsp, clock, reset, cmd.commit, rsp_if.valid)

endmodule
